// ----- sv/clsc_pkg.sv -----
// Shared types, constants and the CRC-16 byte update for the log entry
// seal/check block. No dependencies.
package clsc_pkg;

  // Entry geometry
  localparam int ENTRY_BYTES = 64;
  localparam int TEXT_MAX    = 61;
  localparam int POS_W       = 7;
  localparam int LEN_W       = 6;

  localparam logic [POS_W-1:0] SEAL_LIMIT = POS_W'(ENTRY_BYTES - 3);
  localparam logic [POS_W-1:0] LAST_POS   = POS_W'(ENTRY_BYTES - 1);
  localparam logic [POS_W-1:0] SEARCH_END = POS_W'(TEXT_MAX);
  localparam logic [POS_W-1:0] POS_SAT    = '1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Mode register codes
  localparam logic MODE_SEAL  = 1'b0;
  localparam logic MODE_CHECK = 1'b1;

  // Check verdicts
  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_NO_TERM = 2'd2,
    ST_CRC_ERR = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       entry_end;
  } in_beat_t;

  typedef struct packed {
    logic [LEN_W-1:0] text_length;
    status_t          status;
    logic             out_last;
    logic [7:0]       out_byte;
  } result_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0]  x;
    logic [15:0] xw;
    x  = crc[15:8] ^ b;
    x  = x ^ (x >> 4);
    xw = {8'h00, x};
    return (crc << 8) ^ (xw << 12) ^ (xw << 5) ^ xw;
  endfunction

endpackage

// ----- sv/clsc_in_stage.sv -----
// Input register stage: holds one accepted beat until the engine takes it.
// Depends on clsc_pkg.
module clsc_in_stage
  import clsc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  in_beat_t s_beat,
  input  logic     take,
  output logic     beat_valid,
  output in_beat_t beat
);

  assign s_tready = !beat_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (s_tready) begin
      beat_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      beat <= s_beat;
    end
  end

endmodule

// ----- sv/clsc_engine.sv -----
// Seal/check engine: entry state, CRC update and trailer sequencer.
// Depends on clsc_pkg.
module clsc_engine
  import clsc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     mode,
  input  logic     clear,
  input  logic     beat_valid,
  input  in_beat_t beat,
  output logic     take,
  input  logic     can_load,
  output logic     res_valid,
  output result_t  res
);

  logic [15:0]      crc, crc_next;
  logic [POS_W-1:0] pos, pos_next;
  logic             seen, seen_next;
  logic [LEN_W-1:0] tidx, tidx_next;
  logic             empty, empty_next;
  logic             busy, busy_next;
  logic [15:0]      trail, trail_next;

  logic [15:0] crc_upd;
  logic [7:0]  span_end;
  logic        c_empty, c_seen, c_in_span;
  logic [LEN_W-1:0] c_tidx;
  logic [15:0] c_crc;

  assign crc_upd  = crc_byte(crc, beat.in_byte);
  assign span_end = {2'b00, tidx} + 8'd2;

  // Check-mode update of the entry state by the current byte
  always_comb begin
    c_empty   = empty || (pos == '0 && beat.in_byte == 8'h00);
    c_in_span = !seen || ({1'b0, pos} <= span_end);
    c_crc     = c_in_span ? crc_upd : crc;
    c_seen    = seen;
    c_tidx    = tidx;
    if (!seen && beat.in_byte == 8'h00 && pos <= SEARCH_END) begin
      c_seen = 1'b1;
      c_tidx = pos[LEN_W-1:0];
    end
  end

  always_comb begin
    crc_next   = crc;
    pos_next   = pos;
    seen_next  = seen;
    tidx_next  = tidx;
    empty_next = empty;
    busy_next  = busy;
    trail_next = trail;
    take       = 1'b0;
    res_valid  = 1'b0;
    res        = '0;

    if (busy) begin
      // trailer: CRC high, CRC low, then zero padding to the entry end
      if (can_load) begin
        res_valid    = 1'b1;
        res.out_byte = trail[15:8];
        trail_next   = {trail[7:0], 8'h00};
        if (pos == LAST_POS) begin
          res.out_last = 1'b1;
          busy_next    = 1'b0;
          crc_next     = CRC_INIT;
          pos_next     = '0;
        end else begin
          pos_next = pos + 1'b1;
        end
      end
    end else if (beat_valid) begin
      if (mode == MODE_SEAL) begin
        if (beat.in_byte != 8'h00) begin
          if (pos < SEAL_LIMIT) begin
            if (can_load) begin
              take         = 1'b1;
              res_valid    = 1'b1;
              res.out_byte = beat.in_byte;
              crc_next     = crc_upd;
              pos_next     = pos + 1'b1;
            end
          end else begin
            take = 1'b1;  // overlong text, dropped
          end
        end else if (can_load) begin
          // terminator: emit it, then run the trailer
          take       = 1'b1;
          res_valid  = 1'b1;
          trail_next = crc_upd;
          pos_next   = pos + 1'b1;
          busy_next  = 1'b1;
        end
      end else begin
        if (!beat.entry_end) begin
          take       = 1'b1;
          crc_next   = c_crc;
          empty_next = c_empty;
          seen_next  = c_seen;
          tidx_next  = c_tidx;
          if (pos != POS_SAT) begin
            pos_next = pos + 1'b1;
          end
        end else if (can_load) begin
          take         = 1'b1;
          res_valid    = 1'b1;
          res.out_last = 1'b1;
          priority if (c_empty) begin
            res.status = ST_EMPTY;
          end else if (!c_seen) begin
            res.status = ST_NO_TERM;
          end else begin
            res.status      = (c_crc != 16'h0000) ? ST_CRC_ERR : ST_VALID;
            res.text_length = c_tidx;
          end
          crc_next   = CRC_INIT;
          pos_next   = '0;
          seen_next  = 1'b0;
          tidx_next  = '0;
          empty_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      crc   <= CRC_INIT;
      pos   <= '0;
      seen  <= 1'b0;
      tidx  <= '0;
      empty <= 1'b0;
      busy  <= 1'b0;
    end else begin
      crc   <= crc_next;
      pos   <= pos_next;
      seen  <= seen_next;
      tidx  <= tidx_next;
      empty <= empty_next;
      busy  <= busy_next;
    end
  end

  always_ff @(posedge clk) begin
    trail <= trail_next;
  end

endmodule

// ----- sv/clsc_out_stage.sv -----
// Output register: one result beat, reloadable in the cycle it is taken.
// Depends on clsc_pkg.
module clsc_out_stage
  import clsc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res,
  output logic    can_load,
  output logic    m_tvalid,
  input  logic    m_tready,
  output result_t m_res
);

  assign can_load = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_res <= res;
    end
  end

endmodule

// ----- sv/crc16_log_entry_seal_check.sv -----
// Top level of the CRC-16 log entry seal/check block.
// Depends on clsc_pkg, clsc_in_stage, clsc_engine, clsc_out_stage.
//
// Usage:
//   Slave stream takes one byte per beat (s_tdata = in_byte, s_tlast = entry
//   end marker, used in check mode only). Master stream returns result beats:
//   m_tdata = {text_length, status, out_byte}, m_tlast = out_last.
//   APB register 0 (address 0) is mode: 0 seals text into 64-byte entries
//   with CRC-16/CCITT-FALSE, 1 checks stored entries. Writing mode also
//   clears any entry in progress; write it only while the block is idle.
// Path: an accepted beat is registered in the input register, passes the
//   CRC/state logic and is registered in the output register.
// Throughput: one byte per cycle while the output accepts. In seal mode the
//   terminating zero starts a trailer (CRC high, CRC low, zero padding) that
//   the engine's sequencer emits one beat per cycle while the output accepts;
//   the input stalls until the trailer ends. Dropped overlong text and
//   non-final check bytes are consumed without a result beat.
// Stall: when m_tready is low, the output register holds its beat and the
//   input register fills, then s_tready drops; nothing is lost.
// Reset (rst, synchronous): mode returns to seal, the entry state clears and
//   both stream registers empty.
module crc16_log_entry_seal_check
  import clsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // slave stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // entry_end
  // master stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [9:8] status, [15:10] text_length
  output logic        m_tlast,   // out_last
  // APB configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic ADDR_MODE = 1'b0;  // paddr[2] selects the register word

  logic     mode;
  logic     cfg_wr;
  logic     mode_wr;

  in_beat_t s_beat;
  in_beat_t beat;
  logic     beat_valid;
  logic     take;
  logic     can_load;
  logic     res_valid;
  result_t  res;
  result_t  m_res;

  // APB: zero wait states, write at the access phase
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign mode_wr = cfg_wr && (paddr[2] == ADDR_MODE);
  assign prdata  = (paddr[2] == ADDR_MODE) ? {31'd0, mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_SEAL;
    end else if (mode_wr) begin
      mode <= pwdata[0];
    end
  end

  assign s_beat.in_byte   = s_tdata;
  assign s_beat.entry_end = s_tlast;

  clsc_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_beat     (s_beat),
    .take       (take),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  clsc_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .mode       (mode),
    .clear      (mode_wr),
    .beat_valid (beat_valid),
    .beat       (beat),
    .take       (take),
    .can_load   (can_load),
    .res_valid  (res_valid),
    .res        (res)
  );

  clsc_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (res_valid),
    .res      (res),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_res    (m_res)
  );

  assign m_tdata = {m_res.text_length, m_res.status, m_res.out_byte};
  assign m_tlast = m_res.out_last;

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for crc16_log_entry_seal_check: seals text into CRC-16 entries and checks
// stored entries over the stream ports, with mode set over APB.
// Depends on clsc_pkg and the RTL of the block.
module tb
  import clsc_pkg::*;
();

  // register index 0 lives at byte address 0
  localparam logic [2:0] MODE_REG = 3'd0;

  // ---------------------------------------------------------------------------
  // clock, reset, block inputs (all known from time zero)
  // ---------------------------------------------------------------------------
  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tlast  = 1'b0;
  logic        m_tready = 1'b0;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = 3'd0;
  logic [31:0] pwdata   = 32'h0;

  logic        s_tready;
  logic        m_tvalid;
  logic [15:0] m_tdata;   // [7:0] out_byte, [9:8] status, [15:10] text_length
  logic        m_tlast;   // out_last
  logic [31:0] prdata;
  logic        pready;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  crc16_log_entry_seal_check u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // ---------------------------------------------------------------------------
  // bench state
  // ---------------------------------------------------------------------------
  int unsigned send_gap_pct = 0;   // chance the source holds tvalid low per cycle
  int unsigned sink_gap_pct = 0;   // chance the sink holds tready low per cycle
  int          fault_count  = 0;

  result_t     owed_beats[$];      // result beats the block still owes, oldest first
  logic [7:0]  entry_buf[$];       // stored entry being assembled for check mode

  // shadow of the block: mode register plus entry state
  logic        cur_mode;
  logic [15:0] entry_crc;
  logic [6:0]  entry_pos;
  logic        term_found;
  logic [5:0]  term_at;
  logic        entry_blank;

  // CRC-16/CCITT-FALSE, bit-serial form
  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    int          i;
    r = c ^ {d, 8'h00};
    for (i = 0; i < 8; i++)
      r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
    return r;
  endfunction

  function automatic void owe(input logic [7:0] b, input logic is_end, input status_t st,
                              input logic [5:0] len);
    result_t r;
    r.out_byte    = b;
    r.out_last    = is_end;
    r.status      = st;
    r.text_length = len;
    owed_beats.push_back(r);
  endfunction

  function automatic void clear_entry_state();
    entry_crc   = 16'hFFFF;
    entry_pos   = '0;
    term_found  = 1'b0;
    term_at     = '0;
    entry_blank = 1'b0;
  endfunction

  // Works out the beats one accepted input byte causes and queues them.
  function automatic void predict_byte(input logic [7:0] b, input logic is_end);
    logic [15:0] fcs;
    logic [7:0]  ob;
    int          idx;
    if (cur_mode == MODE_SEAL) begin
      if (b != 8'h00) begin
        // text past the seal limit is dropped silently
        if (entry_pos < SEAL_LIMIT) begin
          entry_crc = crc16_step(entry_crc, b);
          owe(b, 1'b0, ST_VALID, '0);
          entry_pos = entry_pos + 1'b1;
        end
      end else begin
        // trailer: terminator, CRC high, CRC low, zero fill to the entry end
        fcs = crc16_step(entry_crc, 8'h00);
        for (idx = int'(entry_pos); idx < ENTRY_BYTES; idx++) begin
          if (idx == int'(entry_pos) + 1)      ob = fcs[15:8];
          else if (idx == int'(entry_pos) + 2) ob = fcs[7:0];
          else                                 ob = 8'h00;
          owe(ob, idx == ENTRY_BYTES - 1, ST_VALID, '0);
        end
        clear_entry_state();
      end
    end else begin
      if (entry_pos == 0 && b == 8'h00) entry_blank = 1'b1;
      // CRC stops two bytes past the terminator
      if (!term_found || int'(entry_pos) <= int'(term_at) + 2)
        entry_crc = crc16_step(entry_crc, b);
      if (!term_found && b == 8'h00 && entry_pos <= SEARCH_END) begin
        term_found = 1'b1;
        term_at    = entry_pos[5:0];
      end
      if (entry_pos != POS_SAT) entry_pos = entry_pos + 1'b1;
      if (is_end) begin
        if (entry_blank)      owe(8'h00, 1'b1, ST_EMPTY, '0);
        else if (!term_found) owe(8'h00, 1'b1, ST_NO_TERM, '0);
        else owe(8'h00, 1'b1, (entry_crc != 16'h0) ? ST_CRC_ERR : ST_VALID, term_at);
        clear_entry_state();
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (fault_count < 30)
      $display("mismatch %s: got %0h want %0h at t=%0t", what, got, want, $realtime);
    fault_count++;
  endtask

  // ---------------------------------------------------------------------------
  // result sink: random tready, each accepted beat against the oldest owed one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : sink
    result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= sink_gap_pct);
      if (m_tvalid && m_tready) begin
        if (owed_beats.size() == 0) begin
          report_mismatch("unexpected beat", m_tdata, 16'h0);
        end else begin
          want = owed_beats.pop_front();
          if (m_tdata[7:0] !== want.out_byte)
            report_mismatch("out_byte", 16'(m_tdata[7:0]), 16'(want.out_byte));
          if (m_tlast !== want.out_last)
            report_mismatch("out_last", 16'(m_tlast), 16'(want.out_last));
          if (m_tdata[9:8] !== want.status)
            report_mismatch("status", 16'(m_tdata[9:8]), 16'(want.status));
          if (m_tdata[15:10] !== want.text_length)
            report_mismatch("text_length", 16'(m_tdata[15:10]), 16'(want.text_length));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // source side
  // ---------------------------------------------------------------------------
  // One beat in. tvalid stays high into the next call, so back-to-back beats
  // never see a low/high pair of assignments in one step.
  task automatic send_beat(input logic [7:0] b, input logic is_end);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= is_end;
    do @(posedge clk); while (!s_tready);
    predict_byte(b, is_end);
  endtask

  // Source quiet, every owed beat in, then a further wait for dropped bytes
  // still in the two-stage pipe.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (owed_beats.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_idling(input int unsigned src_pct, input int unsigned dst_pct);
    send_gap_pct = src_pct;
    sink_gap_pct = dst_pct;
  endtask

  // ---------------------------------------------------------------------------
  // APB
  // ---------------------------------------------------------------------------
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);           // register takes the write at this edge
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == MODE_REG) begin
      cur_mode = data[0];
      clear_entry_state();
    end
  endtask

  task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    data    = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // mode change only with the block idle; read back what was written
  task automatic set_mode(input logic m);
    logic [31:0] rd;
    drain();
    apb_write(MODE_REG, {31'b0, m});
    apb_read(MODE_REG, rd);
    if (rd !== {31'b0, m}) report_mismatch("mode readback", rd[15:0], {15'b0, m});
  endtask

  // ---------------------------------------------------------------------------
  // entry builders
  // ---------------------------------------------------------------------------
  // text of tlen nonzero chars, terminator, CRC high/low, then pad bytes
  task automatic build_entry(input int tlen, input int pad, input logic pad_noise);
    logic [15:0] fcs;
    int          i;
    entry_buf.delete();
    fcs = 16'hFFFF;
    for (i = 0; i < tlen; i++) begin
      entry_buf.push_back(8'($urandom_range(1, 255)));
      fcs = crc16_step(fcs, entry_buf[i]);
    end
    entry_buf.push_back(8'h00);
    fcs = crc16_step(fcs, 8'h00);
    entry_buf.push_back(fcs[15:8]);
    entry_buf.push_back(fcs[7:0]);
    for (i = 0; i < pad; i++)
      entry_buf.push_back(pad_noise ? 8'($urandom_range(0, 255)) : 8'h00);
  endtask

  // check mode: entry_buf as one entry, end flag on its final byte
  task automatic send_entry();
    int i;
    for (i = 0; i < entry_buf.size(); i++)
      send_beat(entry_buf[i], i == entry_buf.size() - 1);
  endtask

  // seal mode: tlen random nonzero chars then the zero; tlast is noise here
  task automatic send_text(input int tlen);
    int i;
    for (i = 0; i < tlen; i++)
      send_beat(8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)));
    send_beat(8'h00, 1'($urandom_range(0, 1)));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_reset_mode();
    logic [31:0] rd;
    apb_read(MODE_REG, rd);
    if (rd !== {31'b0, MODE_SEAL}) report_mismatch("mode after reset", rd[15:0], 16'h0);
  endtask

  // empty text, byte extremes, tlast ignored while sealing
  task automatic test_seal_basics();
    set_mode(MODE_SEAL);
    send_beat(8'h00, 1'b1);
    send_beat(8'hFF, 1'b1);
    send_beat(8'h00, 1'b0);
    send_beat(8'h01, 1'b0);
    send_beat(8'h80, 1'b1);
    send_beat(8'h7F, 1'b0);
    send_beat(8'h00, 1'b1);
  endtask

  // one of each verdict, plus an entry cut off inside its CRC bytes
  task automatic test_check_verdicts();
    set_mode(MODE_CHECK);
    send_beat(8'h00, 1'b1);                       // empty
    send_beat(8'h41, 1'b0);                       // no terminator
    send_beat(8'hFF, 1'b0);
    send_beat(8'h01, 1'b1);
    build_entry(2, 0, 1'b0);                      // valid
    send_entry();
    build_entry(2, 0, 1'b0);                      // CRC error
    entry_buf[4] = entry_buf[4] ^ 8'h01;
    send_entry();
    build_entry(2, 0, 1'b0);                      // ends before CRC low byte
    void'(entry_buf.pop_back());
    send_entry();
  endtask

  // entry-size edges: full entry with truncation, search limit, position saturation
  task automatic test_long_entries();
    set_mode(MODE_SEAL);
    send_text(ENTRY_BYTES - 2);                   // fills the entry, one char dropped
    set_mode(MODE_CHECK);
    // terminator at the last searched position; zero pad out to position 128,
    // which would read as an empty entry if the position wrapped
    build_entry(TEXT_MAX, 65, 1'b0);
    send_entry();
    build_entry(TEXT_MAX + 1, 0, 1'b0);           // terminator outside search range
    send_entry();
  endtask

  // a mode write drops a half-received entry in either mode
  task automatic test_mode_write_clears();
    set_mode(MODE_CHECK);
    send_beat(8'h51, 1'b0);
    send_beat(8'h00, 1'b0);
    send_beat(8'h33, 1'b0);
    set_mode(MODE_CHECK);
    build_entry(3, 1, 1'b0);
    send_entry();
    set_mode(MODE_SEAL);
    send_beat(8'h52, 1'b0);
    send_beat(8'h53, 1'b0);
    set_mode(MODE_SEAL);
    send_beat(8'h00, 1'b0);
  endtask

  task automatic random_seal(input int n_bytes);
    int sent;
    int pick;
    int tlen;
    sent = 0;
    while (sent < n_bytes) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)     tlen = $urandom_range(55, 70);
      else if (pick < 4) tlen = $urandom_range(9, 40);
      else               tlen = $urandom_range(0, 8);
      send_text(tlen);
      sent += tlen + 1;
    end
  endtask

  // half well-formed entries, the rest corrupted or plain noise
  task automatic random_check(input int n_entries);
    int e;
    int i;
    int kind;
    int tlen;
    int cut;
    int n;
    for (e = 0; e < n_entries; e++) begin
      kind = $urandom_range(0, 9);
      tlen = ($urandom_range(0, 19) == 0) ? $urandom_range(7, TEXT_MAX) : $urandom_range(0, 6);
      build_entry(tlen, $urandom_range(0, 3), 1'($urandom_range(0, 1)));
      case (kind)
        5: begin
          i = $urandom_range(0, tlen + 2);
          entry_buf[i] = entry_buf[i] ^ (8'h01 << $urandom_range(0, 7));
        end
        6: begin
          cut = $urandom_range(1, tlen + 2);
          while (entry_buf.size() > cut) void'(entry_buf.pop_back());
        end
        7: entry_buf[0] = 8'h00;
        8: begin
          n = $urandom_range(1, 8);
          entry_buf.delete();
          for (i = 0; i < n; i++) entry_buf.push_back(8'($urandom_range(1, 255)));
        end
        default: ;
      endcase
      if (kind == 9) begin
        // garbage with stray end flags
        n = $urandom_range(1, 10);
        for (i = 0; i < n; i++)
          send_beat(8'($urandom_range(0, 255)), i == n - 1 || $urandom_range(0, 4) == 0);
      end else begin
        send_entry();
      end
    end
  endtask

  task automatic random_phase(input int unsigned src_pct, input int unsigned dst_pct);
    set_idling(src_pct, dst_pct);
    set_mode(MODE_SEAL);
    random_seal(8);
    set_mode(MODE_CHECK);
    random_check(3);
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    cur_mode = MODE_SEAL;
    clear_entry_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_reset_mode();
    set_idling(17, 70);
    test_seal_basics();
    test_check_verdicts();
    random_phase(17, 70);

    set_idling(70, 17);
    test_long_entries();
    test_mode_write_clears();
    random_phase(70, 17);

    random_phase(0, 0);

    drain();
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/clsc_pkg.sv
sv/clsc_in_stage.sv
sv/clsc_engine.sv
sv/clsc_out_stage.sv
sv/crc16_log_entry_seal_check.sv
bench/tb.sv
